// ===== design/fpa_pkg.sv =====
`default_nettype none
package fpa_pkg;

	localparam int unsigned DATA_W = 32;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_MIN = 3'd4;
	localparam logic [2:0] MODE_MAX = 3'd5;
	localparam logic [2:0] MODE_I2F = 3'd6;
	localparam logic [2:0] MODE_F2I = 3'd7;

	// per-item fields that ride alongside the divider
	typedef struct packed {
		logic [2:0]        mode;
		logic [DATA_W-1:0] ua;
		logic [DATA_W-1:0] ub;
		logic              gt;
		logic              lt;
		logic              eq;
		logic              neg_a;
		logic              neg_res;
		logic [DATA_W-1:0] ma;
		logic [DATA_W-1:0] mb;
		logic [63:0]       prod;
	} side_t;

endpackage
`default_nettype wire

// ===== design/fixed_point_alu_top.sv =====
`default_nettype none
// Path: decode register, divider chain, rounding register, output register.
// Throughput: one transfer per cycle unless stalled; one divider restoring step per stage.
// The whole pipeline holds while a result waits on m_tready.
// Reset (arst_n low, asynchronous) clears all valid bits; the pipeline comes up empty.
module fixed_point_alu_top #(
	parameter int unsigned FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // operand_a, operand_b
	input  wire logic [2:0]  s_tuser,  // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // result
	output logic [4:0]       m_tuser   // a_greater, a_less, a_equal, overflow, divide_by_zero
);
	import fpa_pkg::*;

	localparam int unsigned NW = DATA_W + FRAC_BITS;

	logic en;

	// decode stage
	logic  valid_s1;
	side_t side_s1;
	logic [31:0] a_in, b_in, ma_in, mb_in;

	// divider chain
	logic          v_c    [NW+1];
	side_t         side_c [NW+1];
	logic [31:0]   rem_c  [NW+1];
	logic [NW-1:0] quo_c  [NW+1];

	// rounding stage
	logic        valid_s2;
	logic [63:0] mag_s2;
	logic        neg_s2, sat_en_s2, dbz_s2;
	logic [31:0] raw_s2;
	logic [2:0]  cmp_s2;

	// output stage
	logic        valid_s3;
	logic [31:0] res_s3;
	logic        ovf_s3, dbz_s3;
	logic [2:0]  cmp_s3;

	assign en       = ~valid_s3 | m_tready;
	assign s_tready = en;

	assign a_in  = s_tdata[31:0];
	assign b_in  = s_tdata[63:32];
	assign ma_in = a_in[31] ? (32'd0 - a_in) : a_in;
	assign mb_in = b_in[31] ? (32'd0 - b_in) : b_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.mode    <= s_tuser;
			side_s1.ua      <= a_in;
			side_s1.ub      <= b_in;
			side_s1.gt      <= $signed(a_in) > $signed(b_in);
			side_s1.lt      <= $signed(a_in) < $signed(b_in);
			side_s1.eq      <= a_in == b_in;
			side_s1.neg_a   <= a_in[31];
			side_s1.neg_res <= a_in[31] ^ b_in[31];
			side_s1.ma      <= ma_in;
			side_s1.mb      <= mb_in;
			side_s1.prod    <= 64'd0;
		end
	end

	// product is formed in the first divider stage's input
	always_comb begin
		side_c[0]      = side_s1;
		side_c[0].prod = {32'd0, side_s1.ma} * {32'd0, side_s1.mb};
	end
	assign v_c[0]   = valid_s1;
	assign rem_c[0] = 32'd0;
	assign quo_c[0] = NW'({32'd0, side_s1.ma} << FRAC_BITS);

	for (genvar i = 0; i < NW; i++) begin : g_div
		fpa_div_step #(.NW(NW)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_c[i]),
			.in_side   (side_c[i]),
			.in_rem    (rem_c[i]),
			.in_quo    (quo_c[i]),
			.out_valid (v_c[i+1]),
			.out_side  (side_c[i+1]),
			.out_rem   (rem_c[i+1]),
			.out_quo   (quo_c[i+1])
		);
	end

	side_t       sd;
	logic [63:0] q_rnd, p_rnd, mag_n;
	logic        neg_n, sat_n, dbz_n;
	logic [31:0] raw_n;

	assign sd    = side_c[NW];
	assign q_rnd = 64'(quo_c[NW]) +
		64'({rem_c[NW], 1'b0} >= {1'b0, sd.mb});
	assign p_rnd = (sd.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

	always_comb begin
		mag_n = 64'd0;
		neg_n = sd.neg_res;
		sat_n = 1'b0;
		dbz_n = 1'b0;
		raw_n = 32'd0;
		case (sd.mode)
			MODE_ADD: raw_n = sd.ua + sd.ub;
			MODE_SUB: raw_n = sd.ua - sd.ub;
			MODE_MUL: begin
				mag_n = p_rnd;
				sat_n = 1'b1;
			end
			MODE_DIV: begin
				if (sd.mb == 32'd0) begin
					dbz_n = 1'b1;
				end else begin
					mag_n = q_rnd;
					sat_n = 1'b1;
				end
			end
			MODE_MIN: raw_n = sd.lt ? sd.ua : sd.ub;
			MODE_MAX: raw_n = sd.gt ? sd.ua : sd.ub;
			MODE_I2F: begin
				mag_n = {32'd0, sd.ma} << FRAC_BITS;
				neg_n = sd.neg_a;
				sat_n = 1'b1;
			end
			MODE_F2I: raw_n = 32'($signed(sd.ua) >>> FRAC_BITS);
			default: raw_n = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= v_c[NW];
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2    <= mag_n;
			neg_s2    <= neg_n;
			sat_en_s2 <= sat_n;
			dbz_s2    <= dbz_n;
			raw_s2    <= raw_n;
			cmp_s2    <= {sd.eq, sd.lt, sd.gt};
		end
	end

	// sign and saturate, or pass the raw result through
	always_ff @(posedge clk) begin
		if (en) begin
			dbz_s3 <= dbz_s2;
			cmp_s3 <= cmp_s2;
			ovf_s3 <= 1'b0;
			if (!sat_en_s2) begin
				res_s3 <= raw_s2;
			end else if (neg_s2) begin
				if (mag_s2 > 64'h8000_0000) begin
					res_s3 <= 32'h8000_0000;
					ovf_s3 <= 1'b1;
				end else begin
					res_s3 <= 32'd0 - mag_s2[31:0];
				end
			end else begin
				if (mag_s2 > 64'h7FFF_FFFF) begin
					res_s3 <= 32'h7FFF_FFFF;
					ovf_s3 <= 1'b1;
				end else begin
					res_s3 <= mag_s2[31:0];
				end
			end
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = res_s3;
	assign m_tuser  = {dbz_s3, ovf_s3, cmp_s3};

endmodule
`default_nettype wire

// ===== design/fpa_div_step.sv =====
`default_nettype none
module fpa_div_step #(
	parameter int unsigned NW = 40
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire fpa_pkg::side_t       in_side,
	input  wire logic [31:0]          in_rem,
	input  wire logic [NW-1:0]        in_quo,
	output logic                      out_valid,
	output fpa_pkg::side_t            out_side,
	output logic [31:0]               out_rem,
	output logic [NW-1:0]             out_quo
);
	import fpa_pkg::*;

	logic [32:0] trial;
	logic [32:0] diff;
	logic        take;
	logic        valid_s1;
	side_t       side_s1;
	logic [31:0] rem_s1;
	logic [NW-1:0] quo_s1;

	// one restoring step: numerator bits leave the top of quo, quotient bits enter below
	assign trial = {in_rem, in_quo[NW-1]};
	assign diff  = trial - {1'b0, in_side.mb};
	assign take  = ~diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			rem_s1  <= take ? diff[31:0] : trial[31:0];
			quo_s1  <= {in_quo[NW-2:0], take};
		end
	end

	assign out_valid = valid_s1;
	assign out_side  = side_s1;
	assign out_rem   = rem_s1;
	assign out_quo   = quo_s1;

endmodule
`default_nettype wire

// ===== design/fpa_checker.sv =====
`default_nettype none
module fpa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [4:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(m_tuser[2:0]))
		else $error("compare flags not one-hot");

	a_dbz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4] |-> m_tdata == 32'd0 && !m_tuser[3])
		else $error("divide by zero result not clean");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000)
		else $error("overflow without saturated result");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with output free");

endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== verif/fixed_point_alu_checker.sv =====
`timescale 1ns / 100ps
module fixed_point_alu_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic [2:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	input  wire logic [4:0]  m_tuser,
	output int               fail_count,
	output int               pending
);
	import fpa_pkg::*;

	localparam int FRAC = 8;

	typedef struct packed {
		logic [31:0] result;
		logic [4:0]  flags;
	} alu_out_t;

	alu_out_t expected_q[$];
	assign pending = expected_q.size();

	function automatic logic [31:0] saturate(input logic neg, input logic [63:0] mag,
			inout logic sat);
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return 32'd0 - mag[31:0];
		end
		if (mag > 64'h7FFF_FFFF) begin
			sat = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return mag[31:0];
	endfunction

	function automatic alu_out_t alu_predict(input logic [2:0] mode,
			input logic [31:0] ua, input logic [31:0] ub);
		logic gt, lt, sat, dbz, neg_a, neg_b;
		logic [63:0] ma, mb, p, n, q, r;
		logic [31:0] res;
		alu_out_t o;
		gt = $signed(ua) > $signed(ub);
		lt = $signed(ua) < $signed(ub);
		neg_a = ua[31];
		neg_b = ub[31];
		ma = neg_a ? {32'd0, 32'd0 - ua} : {32'd0, ua};
		mb = neg_b ? {32'd0, 32'd0 - ub} : {32'd0, ub};
		sat = 1'b0;
		dbz = 1'b0;
		res = '0;
		case (mode)
			MODE_ADD: res = ua + ub;
			MODE_SUB: res = ua - ub;
			MODE_MUL: begin
				p = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
				res = saturate(neg_a != neg_b, p, sat);
			end
			MODE_DIV: begin
				if (mb == 0) begin
					dbz = 1'b1;
				end else begin
					n = ma << FRAC;
					q = n / mb;
					r = n % mb;
					if (2 * r >= mb)
						q++;
					res = saturate(neg_a != neg_b, q, sat);
				end
			end
			MODE_MIN: res = lt ? ua : ub;
			MODE_MAX: res = gt ? ua : ub;
			MODE_I2F: res = saturate(neg_a, ma << FRAC, sat);
			default:  res = $unsigned($signed(ua) >>> FRAC);
		endcase
		o.result = res;
		o.flags = {dbz, sat, ua == ub, lt, gt};
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alu_out_t e;
		int errs;
		if (!arst_n) begin
			fail_count <= 0;
			expected_q.delete();
		end else begin
			errs = 0;
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with nothing expected: %h %b", m_tdata, m_tuser);
					errs++;
				end else begin
					e = expected_q.pop_front();
					if (e.result !== m_tdata) begin
						$error("result: expected %h, actual %h", e.result, m_tdata);
						errs++;
					end
					if (e.flags !== m_tuser) begin
						$error("flags (a_greater..divide_by_zero): expected %b, actual %b",
							e.flags, m_tuser);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			if (s_tvalid && s_tready)
				expected_q.push_back(alu_predict(s_tuser, s_tdata[31:0], s_tdata[63:32]));
		end
	end
endmodule

// ===== verif/fixed_point_alu_top_test.sv =====
`timescale 1ns / 100ps
module fixed_point_alu_top_test;
	import fpa_pkg::*;

	localparam int LATENCY = 43;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [4:0] m_tuser;
	int fail_count, pending;
	int cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	fixed_point_alu_top u_top (.*);

	fixed_point_alu_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("fixed_point_alu_top_test: done, errors");
			$finish;
		end
	end

	// receiver stall pattern: long open stretches mixed with choppy ones
	always @(negedge clk) begin
		if (cycles % 1024 < 256)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'd0;
			3: return $urandom_range(0, 1) ? 32'h0000_0100 : 32'hFFFF_FF00;
			4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			5: return {{24{$urandom_range(0, 1) == 1}}, 8'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic send_op(input logic [2:0] mode, input logic [31:0] a, input logic [31:0] b);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {b, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	initial begin
		int burst;
		logic [2:0] m;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners
		send_op(MODE_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
		send_op(MODE_SUB, 32'h8000_0000, 32'h0000_0001);
		send_op(MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_op(MODE_MUL, 32'h8000_0000, 32'h0000_0100);
		send_op(MODE_MUL, 32'h8000_0000, 32'h0000_0101);
		send_op(MODE_MUL, 32'h0000_0001, 32'h0000_0080);
		send_op(MODE_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
		send_op(MODE_DIV, 32'h0000_0100, 32'h0000_0000);
		send_op(MODE_DIV, 32'h8000_0000, 32'h0000_0000);
		send_op(MODE_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
		send_op(MODE_DIV, 32'h8000_0000, 32'h0000_0100);
		send_op(MODE_DIV, 32'h8000_0000, 32'hFFFF_FF00);
		send_op(MODE_DIV, 32'h0000_0001, 32'h0000_0200);
		send_op(MODE_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
		send_op(MODE_MIN, 32'h1234_5678, 32'h1234_5678);
		send_op(MODE_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
		send_op(MODE_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
		send_op(MODE_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(MODE_I2F, 32'h007F_FFFF, 32'hFFFF_FFFF);
		send_op(MODE_I2F, 32'h0080_0000, 32'h0);
		send_op(MODE_I2F, 32'hFF80_0000, 32'h0);
		send_op(MODE_I2F, 32'hFF7F_FFFF, 32'h8000_0000);
		send_op(MODE_F2I, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_op(MODE_F2I, 32'h8000_0000, 32'h0);
		send_op(MODE_F2I, 32'h7FFF_FFFF, 32'h0);

		// hold off until the pipeline has drained completely
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);

		for (int i = 0; i < 1450;) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++) begin
				m = 3'($urandom_range(0, 7));
				send_op(m, pick_operand(), ($urandom_range(0, 9) == 0) ? 32'd0 : pick_operand());
				i++;
			end
			if ($urandom_range(0, 2) != 0)
				idle($urandom_range(1, 12));
		end

		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0)
			$display("fixed_point_alu_top_test: done, clean");
		else
			$display("fixed_point_alu_top_test: done, errors");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/fpa_pkg.sv
design/fpa_div_step.sv
design/fixed_point_alu_top.sv
design/fpa_checker.sv
verif/fixed_point_alu_checker.sv
verif/fixed_point_alu_top_test.sv
